/* rtl/bat_pkg.sv */
package bat_pkg;

   // tag type and array subtype characters
   localparam logic [7:0] CH_UA = 8'h41;  // 'A'
   localparam logic [7:0] CH_LC = 8'h63;  // 'c'
   localparam logic [7:0] CH_UC = 8'h43;  // 'C'
   localparam logic [7:0] CH_LS = 8'h73;  // 's'
   localparam logic [7:0] CH_US = 8'h53;  // 'S'
   localparam logic [7:0] CH_LI = 8'h69;  // 'i'
   localparam logic [7:0] CH_UI = 8'h49;  // 'I'
   localparam logic [7:0] CH_LF = 8'h66;  // 'f'
   localparam logic [7:0] CH_UZ = 8'h5A;  // 'Z'
   localparam logic [7:0] CH_UH = 8'h48;  // 'H'
   localparam logic [7:0] CH_UB = 8'h42;  // 'B'

   typedef enum logic [3:0] {
      PH_KEY0,
      PH_KEY1,
      PH_TYPE,
      PH_SCALAR,
      PH_STRING,
      PH_SUB,
      PH_COUNT,
      PH_ELEM,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_SCALAR = 3'd0,
      KIND_CHAR   = 3'd1,
      KIND_STREND = 3'd2,
      KIND_ELEM   = 3'd3,
      KIND_EMPTY  = 3'd4,
      KIND_ERROR  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        tag_key;
      logic [7:0]         type_code;
      logic [7:0]         elem_type;
      logic signed [63:0] value;
      logic [31:0]        element_index;
      logic               last_element;
   } rsp_type;

   // byte size of a scalar type, zero when not a scalar type
   function automatic logic [2:0] scalar_size(input logic [7:0] t);
      logic [2:0] sz;
      begin
         unique case (t)
            CH_UA, CH_LC, CH_UC: sz = 3'd1;
            CH_LS, CH_US:        sz = 3'd2;
            CH_LI, CH_UI, CH_LF: sz = 3'd4;
            default:             sz = 3'd0;
         endcase
         return sz;
      end
   endfunction

   function automatic logic [63:0] extend(input logic [7:0] t, input logic [31:0] acc);
      logic [63:0] v;
      begin
         unique case (t)
            CH_LC:        v = {{56{acc[7]}}, acc[7:0]};
            CH_LS:        v = {{48{acc[15]}}, acc[15:0]};
            CH_LI:        v = {{32{acc[31]}}, acc};
            CH_UA, CH_UC: v = {56'd0, acc[7:0]};
            CH_US:        v = {48'd0, acc[15:0]};
            default:      v = {32'd0, acc};
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/bat_parse.sv */
module bat_parse
   import bat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       block_end,
   output logic       res_valid,
   output rsp_type    res
);

   phase_type   phase_ff, phase_in;
   logic [15:0] key_ff, key_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sub_ff, sub_in;
   logic [2:0]  byte_pos_ff, byte_pos_in;
   logic [31:0] value_acc_ff, value_acc_in;
   logic [31:0] array_count_ff, array_count_in;
   logic [31:0] elem_counter_ff, elem_counter_in;
   logic        key_valid_ff, key_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_KEY0;
         key_ff          <= '0;
         type_ff         <= '0;
         sub_ff          <= '0;
         byte_pos_ff     <= '0;
         value_acc_ff    <= '0;
         array_count_ff  <= '0;
         elem_counter_ff <= '0;
         key_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         key_ff          <= key_in;
         type_ff         <= type_in;
         sub_ff          <= sub_in;
         byte_pos_ff     <= byte_pos_in;
         value_acc_ff    <= value_acc_in;
         array_count_ff  <= array_count_in;
         elem_counter_ff <= elem_counter_in;
         key_valid_ff    <= key_valid_in;
      end
   end

   always_comb begin
      logic [31:0] byte_word;
      logic [31:0] acc_new;
      logic [2:0]  pos_inc;
      logic        make_err;
      logic        err_sub;
      logic        close;
      logic        emit;
      logic        fin;
      rsp_type     rec;

      phase_in        = phase_ff;
      key_in          = key_ff;
      type_in         = type_ff;
      sub_in          = sub_ff;
      byte_pos_in     = byte_pos_ff;
      value_acc_in    = value_acc_ff;
      array_count_in  = array_count_ff;
      elem_counter_in = elem_counter_ff;
      key_valid_in    = key_valid_ff;

      byte_word = 32'(data_byte) << {byte_pos_ff[1:0], 3'b000};
      acc_new   = value_acc_ff | byte_word;
      pos_inc   = byte_pos_ff + 3'd1;
      make_err  = 1'b0;
      err_sub   = 1'b0;
      close     = 1'b0;
      emit      = 1'b0;
      fin       = (elem_counter_ff == array_count_ff - 32'd1);
      rec       = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_KEY0: begin
               key_valid_in = 1'b0;
               key_in       = {data_byte, 8'h00};
               if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end else begin
                  phase_in = PH_KEY1;
               end
            end
            PH_KEY1: begin
               key_in = {key_ff[15:8], data_byte};
               if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in         = data_byte;
               sub_in          = 8'h00;
               key_valid_in    = 1'b1;
               byte_pos_in     = 3'd0;
               value_acc_in    = 32'd0;
               elem_counter_in = 32'd0;
               if (scalar_size(data_byte) != 3'd0 || data_byte == CH_UZ ||
                   data_byte == CH_UH || data_byte == CH_UB) begin
                  if (scalar_size(data_byte) != 3'd0) begin
                     phase_in = PH_SCALAR;
                  end else if (data_byte == CH_UB) begin
                     phase_in = PH_SUB;
                  end else begin
                     phase_in = PH_STRING;
                  end
                  if (block_end) begin
                     make_err = 1'b1;
                     close    = 1'b1;
                  end
               end else begin
                  // unknown type: report now, drop bytes up to block end
                  make_err = 1'b1;
                  if (block_end) begin
                     close = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SCALAR: begin
               value_acc_in = acc_new;
               byte_pos_in  = pos_inc;
               if (pos_inc >= scalar_size(type_ff)) begin
                  emit              = 1'b1;
                  close             = 1'b1;
                  rec.kind          = KIND_SCALAR;
                  rec.tag_key       = key_ff;
                  rec.type_code     = type_ff;
                  rec.value         = extend(type_ff, acc_new);
               end else if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end
            end
            PH_STRING: begin
               if (data_byte == 8'h00) begin
                  emit              = 1'b1;
                  close             = 1'b1;
                  rec.kind          = KIND_STREND;
                  rec.tag_key       = key_ff;
                  rec.type_code     = type_ff;
                  rec.element_index = elem_counter_ff;
               end else if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end else begin
                  emit              = 1'b1;
                  rec.kind          = KIND_CHAR;
                  rec.tag_key       = key_ff;
                  rec.type_code     = type_ff;
                  rec.value         = 64'(data_byte);
                  rec.element_index = elem_counter_ff;
                  elem_counter_in   = elem_counter_ff + 32'd1;
               end
            end
            PH_SUB: begin
               sub_in  = data_byte;
               err_sub = 1'b1;
               if (data_byte == CH_UA || scalar_size(data_byte) == 3'd0) begin
                  make_err = 1'b1;
                  if (block_end) begin
                     close = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end else begin
                  byte_pos_in    = 3'd0;
                  array_count_in = 32'd0;
                  phase_in       = PH_COUNT;
               end
            end
            PH_COUNT: begin
               array_count_in = array_count_ff | byte_word;
               byte_pos_in    = pos_inc;
               err_sub        = 1'b1;
               if (pos_inc >= 3'd4) begin
                  if ((array_count_ff | byte_word) == 32'd0) begin
                     emit          = 1'b1;
                     close         = 1'b1;
                     rec.kind      = KIND_EMPTY;
                     rec.tag_key   = key_ff;
                     rec.type_code = type_ff;
                     rec.elem_type = sub_ff;
                  end else if (block_end) begin
                     make_err = 1'b1;
                     close    = 1'b1;
                  end else begin
                     byte_pos_in     = 3'd0;
                     value_acc_in    = 32'd0;
                     elem_counter_in = 32'd0;
                     phase_in        = PH_ELEM;
                  end
               end else if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end
            end
            PH_ELEM: begin
               value_acc_in = acc_new;
               byte_pos_in  = pos_inc;
               err_sub      = 1'b1;
               if (pos_inc >= scalar_size(sub_ff)) begin
                  if (!fin && block_end) begin
                     make_err = 1'b1;
                     close    = 1'b1;
                  end else begin
                     emit              = 1'b1;
                     rec.kind          = KIND_ELEM;
                     rec.tag_key       = key_ff;
                     rec.type_code     = type_ff;
                     rec.elem_type     = sub_ff;
                     rec.value         = extend(sub_ff, acc_new);
                     rec.element_index = elem_counter_ff;
                     rec.last_element  = fin;
                     if (fin) begin
                        close = 1'b1;
                     end else begin
                        elem_counter_in = elem_counter_ff + 32'd1;
                        byte_pos_in     = 3'd0;
                        value_acc_in    = 32'd0;
                     end
                  end
               end else if (block_end) begin
                  make_err = 1'b1;
                  close    = 1'b1;
               end
            end
            default: begin
               if (block_end) begin
                  close = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         endcase

         // error fields come from the tag as it stands before it is closed
         if (make_err) begin
            emit          = 1'b1;
            rec           = '0;
            rec.kind      = KIND_ERROR;
            rec.tag_key   = key_valid_in ? key_in : 16'h0000;
            rec.type_code = key_valid_in ? type_in : 8'h00;
            rec.elem_type = err_sub ? sub_in : 8'h00;
         end
         if (close) begin
            phase_in     = PH_KEY0;
            key_valid_in = 1'b0;
         end
      end

      res_valid = emit;
      res       = rec;
   end

endmodule

/* rtl/bat_out_buf.sv */
module bat_out_buf
   import bat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff & out_ready;
   assign space     = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      // the skid entry only fills while the head item is still waiting
      if (push) begin
         if (!main_valid_in) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

endmodule

/* rtl/bam_aux_tag_parser.sv */
// Auxiliary-tag parser for one alignment record: takes one byte of the aux block per cycle while
// req_ready is high and gives at most one result item per byte, registered in the output buffer.
// All parsing for a byte is done between the parser's state registers and a two-entry output
// buffer, so a byte can be taken in every cycle while that buffer has space. req_ready depends
// only on that buffer: it drops only when two results wait, and the sustained rate is one byte
// per cycle as long as the consumer takes results at that rate.
module bam_aux_tag_parser
   import bat_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_block_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [15:0]        rsp_tag_key,
   output logic [7:0]         rsp_type_code,
   output logic [7:0]         rsp_elem_type,
   output logic signed [63:0] rsp_value,
   output logic [31:0]        rsp_element_index,
   output logic               rsp_last_element
);

   logic    accept;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign accept = req_valid & req_ready;

   bat_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .block_end (req_block_end),
      .res_valid (res_valid),
      .res       (res)
   );

   bat_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_kind          = out_data.kind;
   assign rsp_tag_key       = out_data.tag_key;
   assign rsp_type_code     = out_data.type_code;
   assign rsp_elem_type     = out_data.elem_type;
   assign rsp_value         = out_data.value;
   assign rsp_element_index = out_data.element_index;
   assign rsp_last_element  = out_data.last_element;

endmodule

/* rtl/bat_checker.sv */
module bat_checker
   import bat_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_kind,
   input logic [15:0]        rsp_tag_key,
   input logic [7:0]         rsp_type_code,
   input logic [7:0]         rsp_elem_type,
   input logic signed [63:0] rsp_value,
   input logic [31:0]        rsp_element_index,
   input logic               rsp_last_element
);

   // a stalled result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_tag_key)
         && $stable(rsp_type_code) && $stable(rsp_elem_type) && $stable(rsp_value)
         && $stable(rsp_element_index) && $stable(rsp_last_element))
      else $error("result item changed while stalled");

   // after reset nothing is pending and the input side is open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output buffer not empty after reset");

   a_last_only_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_element |-> rsp_kind == KIND_ELEM)
      else $error("last flag on a non-element item");

   a_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STREND || rsp_kind == KIND_EMPTY ||
         rsp_kind == KIND_ERROR) |-> rsp_value == 64'sd0)
      else $error("value not zero on string end, empty array or error");

   // array items always carry a validated subtype
   a_array_sub: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ELEM || rsp_kind == KIND_EMPTY) |-> rsp_elem_type != 8'h00)
      else $error("array item without subtype");

endmodule

bind bam_aux_tag_parser bat_checker u_bat_checker (.*);
